@@ design/u2eb_pkg.sv @@
// ----------------------------------------------------------------------------
// UCS-2 escaped byte encoder package
// Shared types, constant tables and the per-character encoding function.
// ----------------------------------------------------------------------------
package u2eb_pkg;

    typedef logic [15:0] t_code_unit;
    typedef logic [7:0]  t_byte;

    // Number of bytes still to be sent for one character (one to three).
    typedef logic [1:0]  t_rem;

    localparam int CP_COUNT  = 27;
    localparam int RES_COUNT = 23;

    // Code points that map into the CP1252 upper half; they go out as their own low byte.
    localparam t_code_unit CP_POINTS [CP_COUNT] = '{
        16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
        16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
        16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
    };

    // Bytes that must not appear raw inside an escape sequence.
    localparam t_byte RESERVED [RES_COUNT] = '{
        8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20, 8'h0D, 8'h0A,
        8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E, 8'h2F, 8'hBD, 8'h3B, 8'h5D,
        8'h5F, 8'h3D, 8'h23
    };

    localparam t_code_unit SHIFT_LO   = 16'h0100;
    localparam t_code_unit SHIFT_HI   = 16'h0A00;
    localparam t_code_unit SHIFT_ADD  = 16'hE000;
    localparam t_byte      ESC_BASE   = 8'h10;
    localparam t_byte      ESC_HI_INC = 8'd2;
    localparam t_byte      ESC_LO_INC = 8'd1;
    localparam t_byte      LO_ADJ     = 8'd14;
    localparam t_byte      HI_ADJ     = 8'd9;

    localparam t_rem REM_ONE   = 2'd1;
    localparam t_rem REM_TWO   = 2'd2;
    localparam t_rem REM_THREE = 2'd3;

    // Encoded form of one character: bytes in sending order and the byte count.
    typedef struct packed {
        t_byte b0;
        t_byte b1;
        t_byte b2;
        logic  three;
    } t_enc;

    function automatic logic is_cp1252(input t_code_unit cu);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < CP_COUNT; i++) begin
            hit = hit | (cu == CP_POINTS[i]);
        end
        return hit;
    endfunction

    function automatic logic is_reserved(input t_byte b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < RES_COUNT; i++) begin
            hit = hit | (b == RESERVED[i]);
        end
        return hit;
    endfunction

    function automatic t_enc encode(input t_code_unit cu);
        t_code_unit v;
        t_byte      hi;
        t_byte      lo;
        t_byte      esc;
        t_enc       e;
        v = cu;
        if (cu > SHIFT_LO && cu < SHIFT_HI) begin
            v = cu + SHIFT_ADD;
        end
        hi  = v[15:8];
        lo  = v[7:0];
        esc = ESC_BASE;
        if (is_reserved(hi)) begin
            esc = esc + ESC_HI_INC;
            hi  = hi - HI_ADJ;
        end
        if (is_reserved(v[7:0])) begin
            esc = esc + ESC_LO_INC;
            lo  = lo + LO_ADJ;
        end
        if (is_cp1252(cu)) begin
            e.b0    = cu[7:0];
            e.b1    = lo;
            e.b2    = hi;
            e.three = 1'b0;
        end else if (v[15:8] == 8'h00) begin
            e.b0    = v[7:0];
            e.b1    = lo;
            e.b2    = hi;
            e.three = 1'b0;
        end else begin
            e.b0    = esc;
            e.b1    = lo;
            e.b2    = hi;
            e.three = 1'b1;
        end
        return e;
    endfunction

endpackage

@@ design/u2eb_in_if.sv @@
// ----------------------------------------------------------------------------
// UCS-2 code unit channel
// Valid/ready channel carrying one 16-bit code unit per request.
// ----------------------------------------------------------------------------
interface u2eb_in_if
    import u2eb_pkg::*;
;
    logic       valid;
    logic       ready;
    t_code_unit code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

@@ design/u2eb_out_if.sv @@
// ----------------------------------------------------------------------------
// Escaped byte channel
// Valid/ready channel carrying one output byte and its end-of-character flag.
// ----------------------------------------------------------------------------
interface u2eb_out_if
    import u2eb_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last_of_char;

    modport source (output valid, output out_byte, output last_of_char, input ready);
    modport sink   (input valid, input out_byte, input last_of_char, output ready);
endinterface

@@ design/ucs2_escaped_byte_encoder.sv @@
// ----------------------------------------------------------------------------
// UCS-2 escaped byte encoder
// Turns each UCS-2 code unit into one plain byte or a three-byte escape.
// ----------------------------------------------------------------------------
// An accepted code unit is captured in the input register, encoded, and loaded
// into the byte buffer, from which the first byte of the character is offered.
// One character per cycle while the receiver takes every byte and each character
// gives a single byte; a character that needs an escape holds the byte port until
// all three of its bytes have left.
// Reset (synchronous, active low) empties the input register and the byte buffer.
module ucs2_escaped_byte_encoder
    import u2eb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    u2eb_in_if.sink        i_in,
    u2eb_out_if.source     o_out
);

    // Input register: holds one accepted code unit until the byte buffer takes it.
    logic       r_in_valid;
    t_code_unit r_cu;

    // Byte buffer: the encoded character, shifted down one byte per sent byte.
    // r_rem counts the bytes still to go, the current one included.
    logic       r_b_valid;
    t_byte      r_b0;
    t_byte      r_b1;
    t_byte      r_b2;
    t_rem       r_rem;

    logic       n_in_valid;
    t_code_unit n_cu;
    logic       n_b_valid;
    t_byte      n_b0;
    t_byte      n_b1;
    t_byte      n_b2;
    t_rem       n_rem;

    t_enc       enc;
    logic       in_fire;
    logic       out_fire;
    logic       b_last;
    logic       b_load;

    // The whole encoding is combinational table compares and small adds, so
    // it sits between the input register and the byte buffer.
    assign enc = encode(r_cu);

    assign b_last   = (r_rem == REM_ONE);
    assign out_fire = r_b_valid && o_out.ready;

    // The buffer takes a new character when it is empty or its final byte is
    // leaving in this cycle.
    assign b_load   = r_in_valid && (!r_b_valid || (out_fire && b_last));

    // The input register is free when empty or when its contents move on now,
    // so a new request is taken even while a finished byte waits downstream.
    assign i_in.ready = !r_in_valid || b_load;
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid        = r_b_valid;
    assign o_out.out_byte     = r_b0;
    assign o_out.last_of_char = b_last;

    always_comb begin
        n_in_valid = r_in_valid;
        n_cu       = r_cu;
        n_b_valid  = r_b_valid;
        n_b0       = r_b0;
        n_b1       = r_b1;
        n_b2       = r_b2;
        n_rem      = r_rem;

        if (in_fire) begin
            n_in_valid = 1'b1;
            n_cu       = i_in.code_unit;
        end else if (b_load) begin
            n_in_valid = 1'b0;
        end

        if (b_load) begin
            n_b_valid = 1'b1;
            n_b0      = enc.b0;
            n_b1      = enc.b1;
            n_b2      = enc.b2;
            n_rem     = enc.three ? REM_THREE : REM_ONE;
        end else if (out_fire) begin
            if (b_last) begin
                n_b_valid = 1'b0;
                n_rem     = REM_ONE;
            end else begin
                n_b0  = r_b1;
                n_b1  = r_b2;
                n_rem = r_rem - REM_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_b_valid  <= 1'b0;
            r_rem      <= REM_ONE;
        end else begin
            r_in_valid <= n_in_valid;
            r_b_valid  <= n_b_valid;
            r_rem      <= n_rem;
        end
        r_cu <= n_cu;
        r_b0 <= n_b0;
        r_b1 <= n_b1;
        r_b2 <= n_b2;
    end

    // The byte count never reaches zero while a character is buffered.
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_rem != 2'd0))
        else $error("byte buffer holds a character with no bytes left");

    // A byte that is not the last of its character is followed by another one.
    a_escape_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !b_last) |=> (r_b_valid && ($past(r_rem) == r_rem + REM_ONE)))
        else $error("escape sequence broken off before its last byte");

    // An accepted request is held in the input register on the next cycle.
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_in_valid)
        else $error("accepted code unit lost");

    // A held code unit only leaves the input register into the byte buffer.
    a_in_to_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !b_load) |=> (r_in_valid && $stable(r_cu)))
        else $error("code unit dropped from the input register");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UCS-2 escaped byte encoder
// Code units are sent as requests, and each is encoded in the testbench into
// its expected byte sequence. Every byte that leaves the block is checked
// against the oldest expected byte. Directed corner cases come first. Random
// traffic follows, with idle cycles on both sides, a long hold-off at the
// receiver and a pause at the sender until the block has drained.
// ----------------------------------------------------------------------------
module tb;
    import u2eb_pkg::*;

    // A quiet spell this long, with no request moving on either channel, means
    // the block has hung.
    localparam int QUIET_LIMIT   = 2000;
    // The first byte of a character passes only the input register and the byte
    // buffer, so a short tail after draining is enough to catch any stray output.
    localparam int TAIL_CYCLES   = 10;
    localparam int IDLE_PERCENT  = 23;
    localparam int HOLD_OFF_LONG = 80;

    // Encoding rules, restated here so that the prediction owes nothing to
    // the design's own package function.
    localparam t_code_unit WIDE_LOW      = 16'h0100;
    localparam t_code_unit WIDE_HIGH     = 16'h0A00;
    localparam t_code_unit PRIVATE_SHIFT = 16'hE000;
    localparam t_byte      ESCAPE_BASE   = 8'h10;
    localparam t_byte      HIGH_FLAG     = 8'd2;
    localparam t_byte      LOW_FLAG      = 8'd1;
    localparam t_byte      LOW_OFFSET    = 8'd14;
    localparam t_byte      HIGH_OFFSET   = 8'd9;

    localparam int CP1252_COUNT   = 27;
    localparam int RESERVED_COUNT = 23;

    localparam t_code_unit CP1252_POINTS [CP1252_COUNT] = '{
        16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
        16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
        16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
    };

    localparam t_byte RESERVED_BYTES [RESERVED_COUNT] = '{
        8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20, 8'h0D, 8'h0A,
        8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E, 8'h2F, 8'hBD, 8'h3B, 8'h5D,
        8'h5F, 8'h3D, 8'h23
    };

    // One byte that the block is expected to send, with its end-of-character
    // flag.
    typedef struct {
        t_byte value;
        logic  last;
    } t_encoded_byte;

    logic i_clk;
    logic i_rst_n;

    u2eb_in_if  char_in ();
    u2eb_out_if byte_out ();

    ucs2_escaped_byte_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_in),
        .o_out   (byte_out)
    );

    t_encoded_byte pending_bytes[$];
    int            mismatch_count  = 0;
    int            quiet_cycles    = 0;
    int            hold_off_cycles = 0;
    // While set, a side offers or accepts on every cycle; a hold-off still wins.
    bit            sender_steady   = 1'b0;
    bit            sink_steady     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic bit in_cp1252_set(input t_code_unit cu);
        foreach (CP1252_POINTS[i]) begin
            if (CP1252_POINTS[i] == cu) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit is_reserved_byte(input t_byte b);
        foreach (RESERVED_BYTES[i]) begin
            if (RESERVED_BYTES[i] == b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Works out the bytes that one code unit turns into and queues them in
    // sending order.
    function automatic void predict_encoding(input t_code_unit cu);
        t_code_unit v;
        t_byte      hi;
        t_byte      lo;
        t_byte      esc;
        // A CP1252 code point goes out as its own low byte. The points that
        // lie inside the shifted range are caught here, before any shift.
        if (in_cp1252_set(cu)) begin
            pending_bytes.push_back('{cu[7:0], 1'b1});
            return;
        end
        v = cu;
        // Both ends of the range are left alone.
        if (cu > WIDE_LOW && cu < WIDE_HIGH) begin
            v = cu + PRIVATE_SHIFT;
        end
        hi = v[15:8];
        lo = v[7:0];
        // A zero high byte means a plain single byte; the zero code unit is
        // no end of string and comes out as the byte zero.
        if (hi == 8'h00) begin
            pending_bytes.push_back('{lo, 1'b1});
            return;
        end
        esc = ESCAPE_BASE;
        if (is_reserved_byte(hi)) begin
            esc = esc + HIGH_FLAG;
            hi  = hi - HIGH_OFFSET;
        end
        if (is_reserved_byte(lo)) begin
            esc = esc + LOW_FLAG;
            lo  = lo + LOW_OFFSET;
        end
        pending_bytes.push_back('{esc, 1'b0});
        pending_bytes.push_back('{lo, 1'b0});
        pending_bytes.push_back('{hi, 1'b1});
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Every byte accepted by the receiver is compared with the oldest byte
    // still expected. Sampling at the rising edge sees the values that the
    // handshake was made with.
    always @(posedge i_clk) begin : byte_check
        t_encoded_byte want;
        if (i_rst_n && byte_out.valid && byte_out.ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("byte with nothing expected", byte_out.out_byte, 0);
            end else begin
                want = pending_bytes.pop_front();
                if (byte_out.out_byte !== want.value) begin
                    report_mismatch("out_byte", byte_out.out_byte, want.value);
                end
                if (byte_out.last_of_char !== want.last) begin
                    report_mismatch("last_of_char", byte_out.last_of_char, want.last);
                end
            end
        end
    end

    // The watchdog is reset by any request moving on either channel.
    always @(posedge i_clk) begin
        if ((char_in.valid && char_in.ready) || (byte_out.valid && byte_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready is random, high while steady, or low for a long hold-off
    // when one is asked for. The hold-off is counted down here, one cycle at a time.
    // ------------------------------------------------------------------------
    initial begin : byte_sink
        byte_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                byte_out.ready <= 1'b0;
                hold_off_cycles--;
            end else if (sink_steady) begin
                byte_out.ready <= 1'b1;
            end else begin
                byte_out.ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one code unit and waits for the block to take it. It is entered
    // and left just after a falling edge. Valid stays high on the way out, so
    // that back-to-back requests never drop it; an idle cycle, if one is
    // drawn, lowers it in a time step of its own.
    task automatic send_char(input t_code_unit cu);
        while (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
            char_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        char_in.valid     <= 1'b1;
        char_in.code_unit <= cu;
        do begin
            @(posedge i_clk);
        end while (!char_in.ready);
        predict_encoding(cu);
        @(negedge i_clk);
    endtask

    // Stops offering until every expected byte has come out.
    task automatic wait_for_drain();
        char_in.valid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Random code units, weighted towards the cases that matter: CP1252
    // points, plain bytes, the shifted range and reserved bytes in either
    // half. A share of fully random values makes every bit toggle.
    function automatic t_code_unit pick_code_unit();
        int    sel;
        t_byte hi;
        t_byte lo;
        sel = $urandom_range(99);
        hi  = t_byte'($urandom_range(255));
        lo  = t_byte'($urandom_range(255));
        if (sel < 20) begin
            return CP1252_POINTS[$urandom_range(CP1252_COUNT - 1)];
        end else if (sel < 35) begin
            return {8'h00, lo};
        end else if (sel < 55) begin
            return t_code_unit'($urandom_range(WIDE_LOW, WIDE_HIGH));
        end else if (sel < 80) begin
            if ($urandom_range(1)) begin
                hi = RESERVED_BYTES[$urandom_range(RESERVED_COUNT - 1)];
            end
            if ($urandom_range(1)) begin
                lo = RESERVED_BYTES[$urandom_range(RESERVED_COUNT - 1)];
            end
            return {hi, lo};
        end
        return t_code_unit'($urandom_range(16'hFFFF));
    endfunction

    task automatic send_random(input int count);
        repeat (count) begin
            send_char(pick_code_unit());
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases: field extremes, the zero code unit, both edges of the
    // shifted range, CP1252 points inside and outside it, and escapes with
    // neither, either or both halves reserved.
    task automatic test_directed_corners();
        t_code_unit corners[$];
        corners = '{
            16'h0000, 16'hFFFF, 16'h00FF, 16'h0041, 16'h0100, 16'h0101,
            16'h09FF, 16'h0A00, 16'h0A01, 16'h20AC, 16'h017E, 16'h0178,
            16'h0160, 16'h2122, 16'h1234, 16'hA4A4, 16'h2400, 16'h5C41,
            16'h41BD, 16'h0203, 16'h80FF, 16'h5B0D
        };
        foreach (corners[i]) begin
            send_char(corners[i]);
        end
        wait_for_drain();
    endtask

    // Both sides flat out, to run the block at its full rate.
    task automatic test_steady_stream();
        sender_steady = 1'b1;
        sink_steady   = 1'b1;
        send_random(40);
        sink_steady   = 1'b0;
        sender_steady = 1'b0;
    endtask

    // Random idle cycles on both sides, so that gaps can land on any byte of a
    // three-byte escape.
    task automatic test_random_idling();
        send_random(120);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block fills up and has to stall its input.
    task automatic test_output_backpressure();
        sender_steady   = 1'b1;
        hold_off_cycles = HOLD_OFF_LONG;
        send_random(24);
        sender_steady   = 1'b0;
    endtask

    // The sender stops until everything has come out, then starts again from
    // an empty block.
    task automatic test_pause_until_drained();
        send_random(10);
        wait_for_drain();
        send_random(40);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        char_in.valid     = 1'b0;
        char_in.code_unit = '0;
        i_rst_n           = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_steady_stream();
        test_random_idling();
        test_output_backpressure();
        test_pause_until_drained();

        // Let everything drain, then watch a few more cycles for stray bytes.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            report_mismatch("bytes never sent", 0, pending_bytes.size());
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
